// ----- rtl/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Link retry supervisor package
// Shared codes, control/status types and backoff tables.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam logic [1:0] OP_POLL    = 2'd0;
   localparam logic [1:0] OP_OBSERVE = 2'd1;
   localparam logic [1:0] OP_ENABLE  = 2'd2;
   localparam logic [1:0] OP_PROFILE = 2'd3;

   localparam logic [1:0] OC_CONNECTED = 2'd0;
   localparam logic [1:0] OC_AUTH      = 2'd1;
   localparam logic [1:0] OC_TIMEOUT   = 2'd2;
   localparam logic [1:0] OC_LOST      = 2'd3;

   localparam logic [1:0] ACT_NONE       = 2'd0;
   localparam logic [1:0] ACT_CONNECT    = 2'd1;
   localparam logic [1:0] ACT_DISCONNECT = 2'd2;

   localparam logic [2:0] LS_DISABLED   = 3'd0;
   localparam logic [2:0] LS_UNPROV     = 3'd1;
   localparam logic [2:0] LS_IDLE       = 3'd2;
   localparam logic [2:0] LS_CONNECTING = 3'd3;
   localparam logic [2:0] LS_ONLINE     = 3'd4;
   localparam logic [2:0] LS_BACKOFF    = 3'd5;
   localparam logic [2:0] LS_ATTENTION  = 3'd6;

   localparam logic [2:0] FL_NONE      = 3'd0;
   localparam logic [2:0] FL_AUTH      = 3'd1;
   localparam logic [2:0] FL_EXHAUSTED = 3'd2;
   localparam logic [2:0] FL_TIMEOUT   = 3'd3;
   localparam logic [2:0] FL_LOST      = 3'd4;

   localparam logic [7:0]  MAX_ATTEMPTS   = 8'd8;
   localparam logic [16:0] MAX_BACKOFF_MS = 17'd60000;
   localparam logic [31:0] HASH_KEY_MUL   = 32'h9E3779B1;
   localparam logic [31:0] HASH_REV_MUL   = 32'h85EBCA77;
   localparam logic [31:0] HASH_CNT_MUL   = 32'hC2B2AE3D;

   typedef struct packed {
      logic capture;
      logic exec;
      logic hash_step;
      logic div_step;
      logic back_load;
   } lrs_cmd_type;

   typedef struct packed {
      logic need_backoff;
      logic hash_last;
      logic div_last;
   } lrs_status_type;

   // Base delay doubles from 1000 ms and is capped at 50000 ms.
   function automatic logic [15:0] base_delay(input logic [7:0] count);
      logic [15:0] d;
      begin
         if (count <= 8'd1) d = 16'd1000;
         else if (count == 8'd2) d = 16'd2000;
         else if (count == 8'd3) d = 16'd4000;
         else if (count == 8'd4) d = 16'd8000;
         else if (count == 8'd5) d = 16'd16000;
         else if (count == 8'd6) d = 16'd32000;
         else d = 16'd50000;
         return d;
      end
   endfunction

   // One fifth of the base delay.
   function automatic logic [13:0] delay_spread(input logic [7:0] count);
      logic [13:0] s;
      begin
         if (count <= 8'd1) s = 14'd200;
         else if (count == 8'd2) s = 14'd400;
         else if (count == 8'd3) s = 14'd800;
         else if (count == 8'd4) s = 14'd1600;
         else if (count == 8'd5) s = 14'd3200;
         else if (count == 8'd6) s = 14'd6400;
         else s = 14'd10000;
         return s;
      end
   endfunction

endpackage

// ----- rtl/lrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Link retry supervisor controller
// Sequences capture, execution, jitter hashing, modulo, deadline load and response.
// ----------------------------------------------------------------------------
module lrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lrs_pkg::lrs_cmd_type    cmd,
   input  lrs_pkg::lrs_status_type status
);
   import lrs_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EXEC = 6'b000010,
      S_HASH = 6'b000100,
      S_DIV  = 6'b001000,
      S_BACK = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_backoff ? S_HASH : S_RESP;
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_last) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_BACK;
         end
         S_BACK: begin
            cmd.back_load = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted while response pending");
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.exec) else $error("accepted item not executed");
   a_div_back: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> cmd.back_load)
      else $error("modulo end not followed by deadline load");
`endif

endmodule

// ----- rtl/lrs_datapath.sv -----
// ----------------------------------------------------------------------------
// Link retry supervisor datapath
// Supervisor state, operation decode, jitter hash and iterative modulo.
// ----------------------------------------------------------------------------
module lrs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  lrs_pkg::lrs_cmd_type    cmd,
   output lrs_pkg::lrs_status_type status,
   input  logic [1:0]             req_operation,
   input  logic [63:0]            req_now_ms,
   input  logic [1:0]             req_outcome,
   input  logic [31:0]            req_attempt_key,
   input  logic [31:0]            req_attempt_revision,
   input  logic [63:0]            req_attempt_generation,
   input  logic                   req_enable_value,
   input  logic [31:0]            req_new_key,
   input  logic [31:0]            req_new_revision,
   output logic [1:0]             rsp_action,
   output logic                   rsp_accepted,
   output logic [31:0]            rsp_active_key,
   output logic [31:0]            rsp_active_revision,
   output logic [63:0]            rsp_active_generation,
   output logic [2:0]             rsp_link_state,
   output logic [2:0]             rsp_fail_reason,
   output logic [7:0]             rsp_try_count,
   output logic [63:0]            rsp_retry_at_ms
);
   import lrs_pkg::*;

   logic [1:0]  op_ff;
   logic [63:0] now_ff;
   logic [1:0]  oc_ff;
   logic [31:0] akey_ff, arev_ff, nkey_ff, nrev_ff;
   logic [63:0] agen_ff;
   logic        en_ff;

   logic        enabled_ff, enabled_in;
   logic [2:0]  link_ff, link_in;
   logic        pend_ff, pend_in;
   logic [31:0] pkey_ff, pkey_in, prev_ff, prev_in;
   logic [31:0] actkey_ff, actkey_in, actrev_ff, actrev_in;
   logic [63:0] actgen_ff, actgen_in, gen_ff, gen_in;
   logic        reprov_ff, reprov_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [2:0]  fail_ff, fail_in;
   logic [63:0] retry_ff, retry_in;
   logic [1:0]  action_ff, action_in;
   logic        accepted_ff, accepted_in;
   logic        backoff;

   logic [1:0]  hidx_ff;
   logic [63:0] hash_ff;
   logic [15:0] rem_ff;
   logic [4:0]  dcnt_ff;

   logic        busy, obs_ok, fits;
   logic [31:0] rev_eff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [15:0] delay;
   logic [13:0] spread;
   logic [15:0] modulus;
   logic [15:0] r1, r2;
   logic [16:0] jit, jit_cap;
   logic [64:0] dsum;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         now_ff  <= req_now_ms;
         oc_ff   <= req_outcome;
         akey_ff <= req_attempt_key;
         arev_ff <= req_attempt_revision;
         agen_ff <= req_attempt_generation;
         en_ff   <= req_enable_value;
         nkey_ff <= req_new_key;
         nrev_ff <= req_new_revision;
      end
   end

   assign busy    = (link_ff == LS_CONNECTING) || (link_ff == LS_ONLINE);
   assign rev_eff = (nkey_ff == 32'd0) ? 32'd0 : nrev_ff;
   assign obs_ok  = enabled_ff && (pkey_ff != 32'd0) && (agen_ff != 64'd0) &&
                    (akey_ff == actkey_ff) && (arev_ff == actrev_ff) &&
                    (agen_ff == actgen_ff);
   assign fits    = ((link_ff == LS_CONNECTING) && (oc_ff != OC_LOST)) ||
                    ((link_ff == LS_ONLINE) &&
                     ((oc_ff == OC_CONNECTED) || (oc_ff == OC_LOST)));

   always_comb begin
      enabled_in  = enabled_ff;
      link_in     = link_ff;
      pend_in     = pend_ff;
      pkey_in     = pkey_ff;
      prev_in     = prev_ff;
      actkey_in   = actkey_ff;
      actrev_in   = actrev_ff;
      actgen_in   = actgen_ff;
      gen_in      = gen_ff;
      reprov_in   = reprov_ff;
      cnt_in      = cnt_ff;
      fail_in     = fail_ff;
      retry_in    = retry_ff;
      action_in   = action_ff;
      accepted_in = accepted_ff;
      backoff     = 1'b0;
      if (cmd.exec) begin
         action_in   = ACT_NONE;
         accepted_in = 1'b0;
         unique case (op_ff)
            OP_POLL: begin
               if (pend_ff) begin
                  pend_in   = 1'b0;
                  action_in = ACT_DISCONNECT;
               end else if (enabled_ff && (pkey_ff != 32'd0) &&
                            ((link_ff == LS_IDLE) ||
                             ((link_ff == LS_BACKOFF) && (now_ff >= retry_ff)))) begin
                  link_in   = LS_CONNECTING;
                  cnt_in    = (cnt_ff != 8'hFF) ? cnt_ff + 8'd1 : cnt_ff;
                  gen_in    = (gen_ff == '1) ? 64'd1 : gen_ff + 64'd1;
                  actkey_in = pkey_ff;
                  actrev_in = prev_ff;
                  actgen_in = (gen_ff == '1) ? 64'd1 : gen_ff + 64'd1;
                  action_in = ACT_CONNECT;
               end
            end
            OP_OBSERVE: begin
               if (obs_ok && fits) begin
                  accepted_in = 1'b1;
                  if (oc_ff == OC_CONNECTED) begin
                     link_in  = LS_ONLINE;
                     fail_in  = FL_NONE;
                     cnt_in   = 8'd0;
                     retry_in = 64'd0;
                  end else begin
                     actkey_in = 32'd0;
                     actrev_in = 32'd0;
                     actgen_in = 64'd0;
                     if ((oc_ff == OC_AUTH) || (cnt_ff >= MAX_ATTEMPTS)) begin
                        reprov_in = 1'b1;
                        link_in   = LS_ATTENTION;
                        fail_in   = (oc_ff == OC_AUTH) ? FL_AUTH : FL_EXHAUSTED;
                        retry_in  = 64'd0;
                     end else begin
                        link_in = LS_BACKOFF;
                        fail_in = (oc_ff == OC_TIMEOUT) ? FL_TIMEOUT : FL_LOST;
                        backoff = 1'b1;
                     end
                  end
               end
            end
            OP_ENABLE: begin
               if (enabled_ff && !en_ff && busy) pend_in = 1'b1;
               if (!en_ff) begin
                  actkey_in = 32'd0;
                  actrev_in = 32'd0;
                  actgen_in = 64'd0;
               end
               enabled_in = en_ff;
               if (!en_ff) link_in = LS_DISABLED;
               else if (reprov_ff) link_in = LS_ATTENTION;
               else link_in = (pkey_ff != 32'd0) ? LS_IDLE : LS_UNPROV;
            end
            OP_PROFILE: begin
               if ((nkey_ff != pkey_ff) || (rev_eff != prev_ff)) begin
                  if (busy) pend_in = 1'b1;
                  actkey_in = 32'd0;
                  actrev_in = 32'd0;
                  actgen_in = 64'd0;
                  pkey_in   = nkey_ff;
                  prev_in   = rev_eff;
                  reprov_in = 1'b0;
                  fail_in   = FL_NONE;
                  cnt_in    = 8'd0;
                  retry_in  = 64'd0;
                  if (!enabled_ff) link_in = LS_DISABLED;
                  else link_in = (nkey_ff != 32'd0) ? LS_IDLE : LS_UNPROV;
               end
            end
            default: action_in = ACT_NONE;
         endcase
      end else if (cmd.back_load) begin
         retry_in = dsum[64] ? '1 : dsum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         link_ff     <= LS_DISABLED;
         pend_ff     <= 1'b0;
         pkey_ff     <= '0;
         prev_ff     <= '0;
         actkey_ff   <= '0;
         actrev_ff   <= '0;
         actgen_ff   <= '0;
         gen_ff      <= '0;
         reprov_ff   <= 1'b0;
         cnt_ff      <= '0;
         fail_ff     <= FL_NONE;
         retry_ff    <= '0;
         action_ff   <= ACT_NONE;
         accepted_ff <= 1'b0;
      end else begin
         enabled_ff  <= enabled_in;
         link_ff     <= link_in;
         pend_ff     <= pend_in;
         pkey_ff     <= pkey_in;
         prev_ff     <= prev_in;
         actkey_ff   <= actkey_in;
         actrev_ff   <= actrev_in;
         actgen_ff   <= actgen_in;
         gen_ff      <= gen_in;
         reprov_ff   <= reprov_in;
         cnt_ff      <= cnt_in;
         fail_ff     <= fail_in;
         retry_ff    <= retry_in;
         action_ff   <= action_in;
         accepted_ff <= accepted_in;
      end
   end

   // Jitter hash: one product per cycle folded into the hash register.
   always_comb begin
      case (hidx_ff)
         2'd0: begin
            mul_a = pkey_ff;
            mul_b = HASH_KEY_MUL;
         end
         2'd1: begin
            mul_a = prev_ff;
            mul_b = HASH_REV_MUL;
         end
         default: begin
            mul_a = {24'd0, cnt_ff};
            mul_b = HASH_CNT_MUL;
         end
      endcase
   end

   assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
   assign delay   = base_delay(cnt_ff);
   assign spread  = delay_spread(cnt_ff);
   assign modulus = {1'b0, spread, 1'b1};

   // Restoring remainder, two hash bits per cycle.
   always_comb begin
      r1 = {rem_ff[14:0], hash_ff[63]};
      if (r1 >= modulus) r1 = r1 - modulus;
      r2 = {r1[14:0], hash_ff[62]};
      if (r2 >= modulus) r2 = r2 - modulus;
   end

   assign jit     = {1'b0, delay} - {3'd0, spread} + {1'b0, rem_ff};
   assign jit_cap = (jit > MAX_BACKOFF_MS) ? MAX_BACKOFF_MS : jit;
   assign dsum    = {1'b0, now_ff} + {48'd0, jit_cap};

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hidx_ff <= 2'd0;
         hash_ff <= '0;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.hash_step) begin
         hidx_ff <= hidx_ff + 2'd1;
         hash_ff <= hash_ff ^ prod;
      end else if (cmd.div_step) begin
         hash_ff <= {hash_ff[61:0], 2'b00};
         rem_ff  <= r2;
         dcnt_ff <= dcnt_ff + 5'd1;
      end
   end

   assign status.need_backoff = backoff;
   assign status.hash_last    = (hidx_ff == 2'd2);
   assign status.div_last     = (dcnt_ff == 5'd31);

   assign rsp_action            = action_ff;
   assign rsp_accepted          = accepted_ff;
   assign rsp_active_key        = actkey_ff;
   assign rsp_active_revision   = actrev_ff;
   assign rsp_active_generation = actgen_ff;
   assign rsp_link_state        = link_ff;
   assign rsp_fail_reason       = fail_ff;
   assign rsp_try_count         = cnt_ff;
   assign rsp_retry_at_ms       = retry_ff;

`ifndef SYNTHESIS
   a_cnt_connecting: assert property (@(posedge clock) disable iff (reset)
      (link_ff == LS_CONNECTING) |-> (cnt_ff != 8'd0))
      else $error("connecting with no attempt counted");
   a_connect_state: assert property (@(posedge clock) disable iff (reset)
      (action_ff == ACT_CONNECT) |-> (link_ff == LS_CONNECTING))
      else $error("connect issued without connecting state");
   a_backoff_state: assert property (@(posedge clock) disable iff (reset)
      cmd.back_load |-> (link_ff == LS_BACKOFF))
      else $error("deadline load outside backoff");
`endif

endmodule

// ----- rtl/link_retry_supervisor.sv -----
// ----------------------------------------------------------------------------
// Link retry supervisor
// Connection supervisor with exponential backoff and hashed jitter.
// Sequence: execute, then response; an outcome that enters backoff passes through
// 3 hash products, 32 two-bit modulo steps and a deadline add before the response.
// Throughput: one item at a time; next item accepted once the result is taken.
// Reset: synchronous; clears all supervisor state to disabled, no profile.
// ----------------------------------------------------------------------------
module link_retry_supervisor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_now_ms,
   input  logic [1:0]  req_outcome,
   input  logic [31:0] req_attempt_key,
   input  logic [31:0] req_attempt_revision,
   input  logic [63:0] req_attempt_generation,
   input  logic        req_enable_value,
   input  logic [31:0] req_new_key,
   input  logic [31:0] req_new_revision,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic        rsp_accepted,
   output logic [31:0] rsp_active_key,
   output logic [31:0] rsp_active_revision,
   output logic [63:0] rsp_active_generation,
   output logic [2:0]  rsp_link_state,
   output logic [2:0]  rsp_fail_reason,
   output logic [7:0]  rsp_try_count,
   output logic [63:0] rsp_retry_at_ms
);
   import lrs_pkg::*;

   lrs_cmd_type    cmd;
   lrs_status_type status;

   lrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   lrs_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_operation          (req_operation),
      .req_now_ms             (req_now_ms),
      .req_outcome            (req_outcome),
      .req_attempt_key        (req_attempt_key),
      .req_attempt_revision   (req_attempt_revision),
      .req_attempt_generation (req_attempt_generation),
      .req_enable_value       (req_enable_value),
      .req_new_key            (req_new_key),
      .req_new_revision       (req_new_revision),
      .rsp_action             (rsp_action),
      .rsp_accepted           (rsp_accepted),
      .rsp_active_key         (rsp_active_key),
      .rsp_active_revision    (rsp_active_revision),
      .rsp_active_generation  (rsp_active_generation),
      .rsp_link_state         (rsp_link_state),
      .rsp_fail_reason        (rsp_fail_reason),
      .rsp_try_count          (rsp_try_count),
      .rsp_retry_at_ms        (rsp_retry_at_ms)
   );

endmodule
